### src/bra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap run allocator.
// No dependencies; the top level and bra_word_unit use it by scoped names.
package bra_pkg;

   localparam int MAP_BITS = 4096;
   localparam int WORD_W   = 64;
   localparam int WORD_LG  = $clog2(WORD_W);
   localparam int DEPTH    = (MAP_BITS + WORD_W - 1) / WORD_W;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W    = $clog2(DEPTH * WORD_W + 1);

   localparam int INDEX_W  = 21;
   localparam int BASE_W   = 20;
   localparam int COUNT_W  = 13;
   localparam int SUM_W    = INDEX_W + 1;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFREE  = 2'd1,
      ST_RANGE   = 2'd2,
      ST_UNALLOC = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_CHECK,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               cmd;
      logic [INDEX_W-1:0] start_index;
      logic [COUNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] index;
   } rsp_type;

   typedef struct packed {
      logic               has_clear;
      logic [WORD_LG-1:0] clear_bit;
      logic [WORD_W-1:0]  run_mask;
      logic               any_set;
      logic               all_set;
   } word_info_type;

endpackage

### src/bitmap_run_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the bitmap run allocator: sequencer, configuration and result staging.
// Depends on bra_pkg, bra_ram and bra_word_unit.
//
//  channel | ports                                | direction | contents
//  --------+--------------------------------------+-----------+-----------------------------
//  req     | req_valid, req_ready, req_payload    | in        | cmd, start_index, count
//  rsp     | rsp_valid, rsp_ready, rsp_payload    | out       | status, index
//  csr     | csr_valid, csr_ready, csr_data       | in        | index_base (always ready)
//
// The map sits in a 64-word RAM of 64-bit words; one word is read per cycle.
// Allocate: scan from word 0 until a word with a clear bit,
// then an evaluation step, a check pass and a write pass over the run's words,
// then the response is posted. Free skips the scan.
// Reset clears all word valid bits at once; an unwritten word reads as all clear.
// A new request is taken when the sequencer is idle, even while the last response
// still waits on rsp_ready; the sequencer stalls before posting until it drains.
module bitmap_run_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  bra_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output bra_pkg::rsp_type              rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bra_pkg::BASE_W-1:0]    csr_data
);

   bra_pkg::state_type                state_ff, state_in;
   logic                              cmd_ff, cmd_in;
   logic [bra_pkg::INDEX_W-1:0]       start_ff, start_in;
   logic [bra_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [bra_pkg::BASE_W-1:0]        base_ff;
   logic [bra_pkg::POS_W-1:0]         run_start_ff, run_start_in;
   logic [bra_pkg::POS_W-1:0]         run_end_ff, run_end_in;
   logic [bra_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [bra_pkg::ADDR_W-1:0]        first_ff, first_in;
   logic [bra_pkg::ADDR_W-1:0]        last_ff, last_in;
   logic                              issue_ff, issue_in;
   logic                              pend_ff, pend_in;
   logic [bra_pkg::ADDR_W-1:0]        pend_addr_ff, pend_addr_in;
   logic                              rd_vld_ff;
   logic [bra_pkg::DEPTH-1:0]         word_valid_ff;
   bra_pkg::rsp_type                  res_ff, res_in;
   bra_pkg::rsp_type                  rsp_ff;
   logic                              rsp_valid_ff;

   logic                              accept;
   logic                              sweep;
   logic                              ram_rd_en;
   logic                              ram_wr_en;
   logic [bra_pkg::WORD_W-1:0]        ram_rd_data;
   logic [bra_pkg::WORD_W-1:0]        ram_wr_data;
   logic [bra_pkg::WORD_W-1:0]        word;
   bra_pkg::word_info_type            info;
   logic                              at_last;
   logic                              chk_bad;
   logic                              post;

   logic [bra_pkg::INDEX_W-1:0]       eval_pos;
   logic [bra_pkg::SUM_W-1:0]         eval_sum;
   logic [bra_pkg::SUM_W-1:0]         eval_end_m1;
   logic                              eval_ok;
   bra_pkg::status_type               eval_status;

   bra_ram #(
      .WIDTH (bra_pkg::WORD_W),
      .DEPTH (bra_pkg::DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign word = rd_vld_ff ? ram_rd_data : '0;

   bra_word_unit u_word_unit (
      .word      (word),
      .word_addr (pend_addr_ff),
      .run_start (run_start_ff),
      .run_end   (run_end_ff),
      .info      (info)
   );

   assign accept  = req_valid && req_ready;
   assign sweep   = (state_ff == bra_pkg::S_SCAN) || (state_ff == bra_pkg::S_CHECK) ||
                    (state_ff == bra_pkg::S_WRITE);
   assign at_last = pend_ff && (pend_addr_ff == last_ff);
   assign chk_bad = pend_ff && ((cmd_ff == bra_pkg::CMD_ALLOC) ? info.any_set : !info.all_set);
   assign post    = (state_ff == bra_pkg::S_DONE) && (!rsp_valid_ff || rsp_ready);

   // range checks for a run, from the scan result or the free request
   always_comb begin
      if (cmd_ff == bra_pkg::CMD_ALLOC) begin
         eval_pos = bra_pkg::INDEX_W'(run_start_ff);
      end else begin
         eval_pos = start_ff - bra_pkg::INDEX_W'(base_ff);
      end
      eval_sum    = {1'b0, eval_pos} + bra_pkg::SUM_W'(count_ff);
      eval_end_m1 = eval_sum - bra_pkg::SUM_W'(1);
      eval_ok     = 1'b0;
      eval_status = bra_pkg::ST_OK;
      if (cmd_ff == bra_pkg::CMD_ALLOC) begin
         priority if (eval_pos >= bra_pkg::INDEX_W'(bra_pkg::MAP_BITS)) begin
            eval_status = bra_pkg::ST_NOFREE;
         end else if (count_ff == '0 ||
                      eval_sum > bra_pkg::SUM_W'(bra_pkg::MAP_BITS)) begin
            eval_status = bra_pkg::ST_RANGE;
         end else begin
            eval_ok = 1'b1;
         end
      end else begin
         priority if (count_ff == '0 || start_ff < bra_pkg::INDEX_W'(base_ff)) begin
            eval_status = bra_pkg::ST_RANGE;
         end else if (eval_pos > bra_pkg::INDEX_W'(bra_pkg::MAP_BITS) ||
                      eval_sum > bra_pkg::SUM_W'(bra_pkg::MAP_BITS)) begin
            eval_status = bra_pkg::ST_RANGE;
         end else begin
            eval_ok = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bra_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_payload.cmd == bra_pkg::CMD_ALLOC) ? bra_pkg::S_SCAN
                                                                  : bra_pkg::S_EVAL;
            end
         end
         bra_pkg::S_SCAN: begin
            priority if (pend_ff && info.has_clear) begin
               state_in = bra_pkg::S_EVAL;
            end else if (at_last) begin
               state_in = bra_pkg::S_DONE;
            end else begin
               state_in = bra_pkg::S_SCAN;
            end
         end
         bra_pkg::S_EVAL: begin
            state_in = eval_ok ? bra_pkg::S_CHECK : bra_pkg::S_DONE;
         end
         bra_pkg::S_CHECK: begin
            priority if (chk_bad) begin
               state_in = bra_pkg::S_DONE;
            end else if (at_last) begin
               state_in = bra_pkg::S_WRITE;
            end else begin
               state_in = bra_pkg::S_CHECK;
            end
         end
         bra_pkg::S_WRITE: begin
            if (at_last) begin
               state_in = bra_pkg::S_DONE;
            end
         end
         bra_pkg::S_DONE: begin
            if (post) begin
               state_in = bra_pkg::S_IDLE;
            end
         end
         default: state_in = bra_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = (state_ff == bra_pkg::S_IDLE);
      ram_rd_en   = sweep && issue_ff;
      ram_wr_en   = (state_ff == bra_pkg::S_WRITE) && pend_ff;
      ram_wr_data = (cmd_ff == bra_pkg::CMD_ALLOC) ? (word | info.run_mask)
                                                   : (word & ~info.run_mask);
   end

   // datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      addr_in      = addr_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      res_in       = res_ff;
      pend_in      = sweep && issue_ff;
      pend_addr_in = addr_ff;
      if (sweep && issue_ff) begin
         if (addr_ff == last_ff) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + bra_pkg::ADDR_W'(1);
         end
      end
      unique case (state_ff)
         bra_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in       = req_payload.cmd;
               start_in     = req_payload.start_index;
               count_in     = req_payload.count;
               addr_in      = '0;
               last_in      = bra_pkg::ADDR_W'(bra_pkg::DEPTH - 1);
               issue_in     = (req_payload.cmd == bra_pkg::CMD_ALLOC);
               pend_in      = 1'b0;
               res_in       = '{status: bra_pkg::ST_OK, index: '0};
            end
         end
         bra_pkg::S_SCAN: begin
            priority if (pend_ff && info.has_clear) begin
               run_start_in = bra_pkg::POS_W'({pend_addr_ff, info.clear_bit});
               issue_in     = 1'b0;
               pend_in      = 1'b0;
            end else if (at_last) begin
               res_in.status = bra_pkg::ST_NOFREE;
            end else begin
               res_in = res_ff;
            end
         end
         bra_pkg::S_EVAL: begin
            pend_in = 1'b0;
            if (eval_ok) begin
               run_start_in = bra_pkg::POS_W'(eval_pos);
               run_end_in   = bra_pkg::POS_W'(eval_sum);
               addr_in      = eval_pos[bra_pkg::WORD_LG +: bra_pkg::ADDR_W];
               first_in     = eval_pos[bra_pkg::WORD_LG +: bra_pkg::ADDR_W];
               last_in      = eval_end_m1[bra_pkg::WORD_LG +: bra_pkg::ADDR_W];
               issue_in     = 1'b1;
            end else begin
               res_in.status = eval_status;
               issue_in      = 1'b0;
            end
         end
         bra_pkg::S_CHECK: begin
            priority if (chk_bad) begin
               res_in.status = (cmd_ff == bra_pkg::CMD_ALLOC) ? bra_pkg::ST_RANGE
                                                              : bra_pkg::ST_UNALLOC;
               issue_in      = 1'b0;
            end else if (at_last) begin
               // rewind for the write pass
               addr_in  = first_ff;
               issue_in = 1'b1;
               pend_in  = 1'b0;
            end else begin
               res_in = res_ff;
            end
         end
         bra_pkg::S_WRITE: begin
            if (at_last && cmd_ff == bra_pkg::CMD_ALLOC) begin
               res_in.index = bra_pkg::INDEX_W'(bra_pkg::INDEX_W'(run_start_ff) +
                                                bra_pkg::INDEX_W'(base_ff));
            end
         end
         bra_pkg::S_DONE: begin
            pend_in = 1'b0;
         end
         default: pend_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bra_pkg::S_IDLE;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         word_valid_ff <= '0;
         base_ff       <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
         if (csr_valid) begin
            base_ff <= csr_data;
         end
         if (ram_wr_en) begin
            word_valid_ff[pend_addr_ff] <= 1'b1;
         end
         if (post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      start_ff     <= start_in;
      count_ff     <= count_in;
      run_start_ff <= run_start_in;
      run_end_ff   <= run_end_in;
      addr_ff      <= addr_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      pend_addr_ff <= pend_addr_in;
      res_ff       <= res_in;
      if (ram_rd_en) begin
         rd_vld_ff <= word_valid_ff[addr_ff];
      end
      if (post) begin
         rsp_ff <= res_ff;
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // the write pass must only see words that the check pass approved
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bra_pkg::S_WRITE && pend_ff && cmd_ff == bra_pkg::CMD_ALLOC)
         |-> !info.any_set)
      else $error("allocate write pass met a set bit");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bra_pkg::S_WRITE && pend_ff && cmd_ff == bra_pkg::CMD_FREE)
         |-> info.all_set)
      else $error("free write pass met a clear bit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != bra_pkg::ST_OK) |-> (rsp_ff.index == '0))
      else $error("refused request carries a nonzero index");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == bra_pkg::S_SCAN || state_ff == bra_pkg::S_EVAL) && !pend_ff)
      else $error("request did not start a clean sweep");

endmodule

### src/bra_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### src/bra_word_unit.sv
`timescale 1ns / 1ps
// Per-word evaluation: lowest clear bit, run mask and run occupancy tests.
// Depends on bra_pkg.
module bra_word_unit (
   input  logic [bra_pkg::WORD_W-1:0] word,
   input  logic [bra_pkg::ADDR_W-1:0] word_addr,
   input  logic [bra_pkg::POS_W-1:0]  run_start,
   input  logic [bra_pkg::POS_W-1:0]  run_end,
   output bra_pkg::word_info_type     info
);

   logic [bra_pkg::POS_W:0]     word_lo;
   logic [bra_pkg::POS_W:0]     word_hi;
   logic [bra_pkg::POS_W:0]     start_x;
   logic [bra_pkg::POS_W:0]     end_x;
   logic [bra_pkg::WORD_LG:0]   lo_amt;
   logic [bra_pkg::WORD_LG:0]   hi_amt;
   logic [bra_pkg::WORD_W-1:0]  mask;

   always_comb begin
      word_lo = (bra_pkg::POS_W + 1)'({word_addr, {bra_pkg::WORD_LG{1'b0}}});
      word_hi = word_lo + (bra_pkg::POS_W + 1)'(bra_pkg::WORD_W);
      start_x = {1'b0, run_start};
      end_x   = {1'b0, run_end};
      if (start_x > word_lo) begin
         lo_amt = (bra_pkg::WORD_LG + 1)'(start_x - word_lo);
      end else begin
         lo_amt = '0;
      end
      if (end_x >= word_hi) begin
         hi_amt = (bra_pkg::WORD_LG + 1)'(bra_pkg::WORD_W);
      end else if (end_x > word_lo) begin
         hi_amt = (bra_pkg::WORD_LG + 1)'(end_x - word_lo);
      end else begin
         hi_amt = '0;
      end
      // shift by the full word width yields zero, which opens the top end
      mask = ({bra_pkg::WORD_W{1'b1}} << lo_amt) & ~({bra_pkg::WORD_W{1'b1}} << hi_amt);
   end

   always_comb begin
      info.has_clear = ~&word;
      info.clear_bit = '0;
      for (int i = bra_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            info.clear_bit = bra_pkg::WORD_LG'(i);
         end
      end
      info.run_mask = mask;
      info.any_set  = |(word & mask);
      info.all_set  = ((word & mask) == mask);
   end

endmodule
